// ----- rtl/core/vtp_pkg.sv -----
package vtp_pkg;

  localparam int NUM_REGS    = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_SEL_W   = $clog2(NUM_REGS);
  localparam int REG_W       = 64;
  localparam int COEF_W      = 32;
  localparam int SUM_W       = 66;
  localparam int MAG_W       = 64;
  localparam int QUO_W       = 32;
  localparam int DIV_STEPS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PRE_SHIFT   = 28;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0]  NO_COLOR    = 8'd127;
  localparam logic [31:0] SCREEN_ONE  = 32'd16;
  localparam logic [31:0] POS_LIMIT   = 32'h7fff_ffff;
  localparam logic [31:0] NEG_LIMIT   = 32'h8000_0000;
  localparam logic [9:0]  RECIP3      = 10'd683;

  localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_0001_0000,
    64'h0,                   64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] alpha;
    logic       last;
  } side_t;

  // classified vertex handed from front to back
  typedef struct packed {
    logic [3:0][MAG_W-1:0] mag;
    logic [3:0]            neg;
    logic                  w_zero;
    side_t                 side;
  } item_t;

  // one stage of the divide pipe, three lanes x, y, z
  typedef struct packed {
    logic [2:0][MAG_W-1:0] rem;
    logic [2:0][QUO_W-1:0] ql;
    logic [2:0]            ovf;
    logic [2:0]            neg;
    logic [MAG_W-1:0]      wm;
    logic                  w_zero;
    side_t                 side;
  } div_t;

  // (2*c)/3 by reciprocal, exact for all byte inputs
  function automatic logic [7:0] scale3(input logic [7:0] c);
    logic [18:0] p;
    p = 19'({c, 1'b0}) * 19'(RECIP3);
    return p[18:11];
  endfunction

endpackage

// ----- rtl/core/vtp_front.sv -----
module vtp_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [vtp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vtp_pkg::REG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [31:0]                  in_pos_x,
  input  logic signed [31:0]                  in_pos_y,
  input  logic signed [31:0]                  in_pos_z,
  input  logic                                in_has_color,
  input  logic [7:0]                          in_red_in,
  input  logic [7:0]                          in_green_in,
  input  logic [7:0]                          in_blue_in,
  input  logic [7:0]                          in_alpha_in,
  input  logic                                in_last_in,
  output logic                                push,
  output vtp_pkg::item_t                      push_item,
  input  logic                                q_full
);

  logic [vtp_pkg::REG_W-1:0] cfg_r [vtp_pkg::NUM_REGS];

  logic                             a_vld_r, b_vld_r, c_vld_r;
  logic signed [63:0]               prod_nxt [4][3];
  logic signed [63:0]               prod_r   [4][3];
  logic signed [31:0]               trans_nxt [4];
  logic signed [31:0]               trans_r   [4];
  logic signed [vtp_pkg::SUM_W-1:0] sum_nxt [4];
  logic signed [vtp_pkg::SUM_W-1:0] sum_r   [4];
  vtp_pkg::side_t                   side_nxt, a_side_r, b_side_r;
  vtp_pkg::item_t                   item_nxt, c_item_r;
  logic signed [31:0]               pos [3];
  logic                             en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vtp_pkg::NUM_REGS; i++) cfg_r[i] <= vtp_pkg::CFG_RESET[i];
    end else if (cfg_valid && cfg_index < vtp_pkg::CFG_IDX_W'(vtp_pkg::NUM_REGS)) begin
      cfg_r[cfg_index[vtp_pkg::CFG_SEL_W-1:0]] <= cfg_data;
    end
  end

  assign en       = !(c_vld_r && q_full);
  assign in_stall = !en;

  // stage a: twelve products and colour scaling
  always_comb begin
    pos[0] = in_pos_x;
    pos[1] = in_pos_y;
    pos[2] = in_pos_z;
    for (int r = 0; r < 4; r++) begin
      prod_nxt[r][0] = $signed(cfg_r[2*r][31:0]) * pos[0];
      prod_nxt[r][1] = $signed(cfg_r[2*r][63:32]) * pos[1];
      prod_nxt[r][2] = $signed(cfg_r[2*r+1][31:0]) * pos[2];
      trans_nxt[r]   = $signed(cfg_r[2*r+1][63:32]);
    end
    if (in_has_color) begin
      side_nxt.red   = vtp_pkg::scale3(in_red_in);
      side_nxt.green = vtp_pkg::scale3(in_green_in);
      side_nxt.blue  = vtp_pkg::scale3(in_blue_in);
      side_nxt.alpha = in_alpha_in[7:1];
    end else begin
      side_nxt.red   = vtp_pkg::NO_COLOR;
      side_nxt.green = vtp_pkg::NO_COLOR;
      side_nxt.blue  = vtp_pkg::NO_COLOR;
      side_nxt.alpha = vtp_pkg::NO_COLOR[6:0];
    end
    side_nxt.last = in_last_in;
  end

  // stage b: exact row sums, translation moved to q32.32
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_nxt[r] = vtp_pkg::SUM_W'(prod_r[r][0]) + vtp_pkg::SUM_W'(prod_r[r][1])
                 + vtp_pkg::SUM_W'(prod_r[r][2])
                 + (vtp_pkg::SUM_W'(trans_r[r]) <<< vtp_pkg::FRAC_BITS);
    end
  end

  // stage c: sign and magnitude, zero w check
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      item_nxt.neg[r] = sum_r[r][vtp_pkg::SUM_W-1];
      item_nxt.mag[r] = sum_r[r][vtp_pkg::SUM_W-1] ?
                        vtp_pkg::MAG_W'(-sum_r[r]) : vtp_pkg::MAG_W'(sum_r[r]);
    end
    item_nxt.w_zero = (sum_r[3] == '0);
    item_nxt.side   = b_side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod_nxt;
      trans_r  <= trans_nxt;
      a_side_r <= side_nxt;
      sum_r    <= sum_nxt;
      b_side_r <= a_side_r;
      c_item_r <= item_nxt;
    end
  end

  assign push      = c_vld_r && !q_full;
  assign push_item = c_item_r;

endmodule

// ----- rtl/core/vtp_queue.sv -----
module vtp_queue #(
  parameter int DEPTH = vtp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vtp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output vtp_pkg::item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vtp_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(do_pop);
    end
  end

endmodule

// ----- rtl/core/vtp_back.sv -----
module vtp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  vtp_pkg::item_t      head_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_red_out,
  output logic [7:0]          out_green_out,
  output logic [7:0]          out_blue_out,
  output logic [6:0]          out_alpha_out,
  output logic signed [31:0]  out_screen_x,
  output logic signed [31:0]  out_screen_y,
  output logic signed [31:0]  out_screen_z,
  output logic signed [31:0]  out_screen_w,
  output logic                out_w_zero,
  output logic                out_last_out
);

  localparam int N = vtp_pkg::DIV_STEPS;

  vtp_pkg::div_t stg_r [N+1];
  logic          vld_r [N+1];
  vtp_pkg::div_t entry;
  logic          en, out_vld_r;
  logic [31:0]   scr_nxt [3];

  function automatic vtp_pkg::div_t div_step(input vtp_pkg::div_t s);
    vtp_pkg::div_t o;
    logic [vtp_pkg::MAG_W:0] t;
    o = s;
    for (int l = 0; l < 3; l++) begin
      t = {s.rem[l], s.ql[l][vtp_pkg::QUO_W-1]};
      if (t >= {1'b0, s.wm}) begin
        o.rem[l] = vtp_pkg::MAG_W'(t - {1'b0, s.wm});
        o.ql[l]  = {s.ql[l][vtp_pkg::QUO_W-2:0], 1'b1};
      end else begin
        o.rem[l] = t[vtp_pkg::MAG_W-1:0];
        o.ql[l]  = {s.ql[l][vtp_pkg::QUO_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  assign en  = !(out_vld_r && out_stall);
  assign pop = en;

  // dividend is 16*c; its top part seeds the remainder
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      entry.rem[l] = vtp_pkg::MAG_W'(head_item.mag[l][vtp_pkg::MAG_W-1:vtp_pkg::PRE_SHIFT]);
      entry.ql[l]  = {head_item.mag[l][vtp_pkg::PRE_SHIFT-1:0], 4'b0};
      entry.ovf[l] = vtp_pkg::MAG_W'(head_item.mag[l][vtp_pkg::MAG_W-1:vtp_pkg::PRE_SHIFT])
                     >= head_item.mag[3];
      entry.neg[l] = head_item.neg[l] ^ head_item.neg[3];
    end
    entry.wm     = head_item.mag[3];
    entry.w_zero = head_item.w_zero;
    entry.side   = head_item.side;
  end

  always_ff @(posedge clk) begin
    if (en) stg_r[0] <= entry;
  end

  for (genvar k = 0; k < N; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) stg_r[k+1] <= div_step(stg_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) vld_r[k] <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= head_valid;
      for (int k = 0; k < N; k++) vld_r[k+1] <= vld_r[k];
      out_vld_r <= vld_r[N];
    end
  end

  // saturate, apply sign, force zero on zero w
  always_comb begin
    logic [31:0] lim, full;
    for (int l = 0; l < 3; l++) begin
      lim  = stg_r[N].neg[l] ? vtp_pkg::NEG_LIMIT : vtp_pkg::POS_LIMIT;
      full = (stg_r[N].ovf[l] || stg_r[N].ql[l] > lim) ? lim : stg_r[N].ql[l];
      if (stg_r[N].w_zero) scr_nxt[l] = '0;
      else if (stg_r[N].neg[l]) scr_nxt[l] = ~full + 32'd1;
      else scr_nxt[l] = full;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_screen_x  <= scr_nxt[0];
      out_screen_y  <= scr_nxt[1];
      out_screen_z  <= scr_nxt[2];
      out_screen_w  <= stg_r[N].w_zero ? '0 : vtp_pkg::SCREEN_ONE;
      out_w_zero    <= stg_r[N].w_zero;
      out_red_out   <= stg_r[N].side.red;
      out_green_out <= stg_r[N].side.green;
      out_blue_out  <= stg_r[N].side.blue;
      out_alpha_out <= stg_r[N].side.alpha;
      out_last_out  <= stg_r[N].side.last;
    end
  end

  assign out_valid = out_vld_r;

endmodule

// ----- rtl/core/vertex_transform_project_top.sv -----
// vertex transform with perspective divide
// input channel: one vertex request per accepted edge (in_valid high, in_stall low)
//   carrying a q16.16 position, optional colour bytes and a batch end mark
// result channel: one result request per vertex, same order, held while out_stall
// config channel: cfg_valid/cfg_ready with cfg_index 0..7 selecting a 64-bit
//   matrix row register; cfg_ready is always high, indexes 8 and up are dropped;
//   write only while the block is idle
// front: three stages (twelve 32x32 products, exact row sums, sign/magnitude)
// queue: small register fifo between front and back, depth QUEUE_DEPTH
// back: 32-step restoring divide pipe for x, y, z sharing the w divisor,
//   then a saturate/sign output register
// throughput: one vertex per cycle, set by the pipelined divide
// latency: 37 cycles from accept to result valid with no stall
// out_stall freezes the back; the front keeps running until the queue fills,
//   then in_stall rises
// reset: synchronous active-low, clears all valid state and loads the identity
//   matrix
module vertex_transform_project_top #(
  parameter int QUEUE_DEPTH = vtp_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vtp_pkg::REG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [31:0]             in_pos_x,
  input  logic signed [31:0]             in_pos_y,
  input  logic signed [31:0]             in_pos_z,
  input  logic                           in_has_color,
  input  logic [7:0]                     in_red_in,
  input  logic [7:0]                     in_green_in,
  input  logic [7:0]                     in_blue_in,
  input  logic [7:0]                     in_alpha_in,
  input  logic                           in_last_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_red_out,
  output logic [7:0]                     out_green_out,
  output logic [7:0]                     out_blue_out,
  output logic [6:0]                     out_alpha_out,
  output logic signed [31:0]             out_screen_x,
  output logic signed [31:0]             out_screen_y,
  output logic signed [31:0]             out_screen_z,
  output logic signed [31:0]             out_screen_w,
  output logic                           out_w_zero,
  output logic                           out_last_out
);

  logic           push, q_full, pop, head_valid;
  vtp_pkg::item_t push_item, head_item;

  // config is always taken
  assign cfg_ready = 1'b1;

  // front: accept, multiply, sum, classify
  vtp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .in_has_color (in_has_color),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .in_alpha_in  (in_alpha_in),
    .in_last_in   (in_last_in),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  // decoupling queue
  vtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // back: divide, saturate, result register
  vtp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_alpha_out (out_alpha_out),
    .out_screen_x  (out_screen_x),
    .out_screen_y  (out_screen_y),
    .out_screen_z  (out_screen_z),
    .out_screen_w  (out_screen_w),
    .out_w_zero    (out_w_zero),
    .out_last_out  (out_last_out)
  );

endmodule

// ----- sim/tb.sv -----
module tb;
  import vtp_pkg::*;

  // register indexes of the matrix rows, plus one that the block must drop
  localparam logic [CFG_IDX_W-1:0] REG_X_A    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_B    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_A    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_B    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Z_A    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Z_B    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_W_A    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_W_B    = 4'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  // coefficient flavors for the random matrices
  localparam int COEF_SMALL   = 0;
  localparam int COEF_FULL    = 1;
  localparam int COEF_EXTREME = 2;

  localparam int DRAIN_CYCLES = 60;    // a bit more than the accept-to-result latency
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 250;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               has_color;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [7:0]         a;
    logic               last;
  } vertex_t;

  typedef struct packed {
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [6:0]         a;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] sw;
    logic               w_zero;
    logic               last;
  } screen_vtx_t;

  typedef struct {
    bit                   wr_cfg;   // drain and write a register before this vertex
    logic [CFG_IDX_W-1:0] idx;
    logic [REG_W-1:0]     val;
    vertex_t              v;
    bit                   typed;    // expected result given in the row
    screen_vtx_t          res;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic in_has_color;
  logic [7:0] in_red_in, in_green_in, in_blue_in, in_alpha_in;
  logic in_last_in;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_red_out, out_green_out, out_blue_out;
  logic [6:0] out_alpha_out;
  logic signed [31:0] out_screen_x, out_screen_y, out_screen_z, out_screen_w;
  logic out_w_zero;
  logic out_last_out;

  // local copy of the matrix rows
  logic [REG_W-1:0] matrix [NUM_REGS];

  screen_vtx_t pending_vtx[$];
  row_t        vec_rows[$];
  int          mismatches;
  int          cycle_cnt;
  int          gap_pct;
  int          stall_pct;

  vertex_transform_project_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .in_has_color (in_has_color),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .in_alpha_in  (in_alpha_in),
    .in_last_in   (in_last_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .out_alpha_out(out_alpha_out),
    .out_screen_x (out_screen_x),
    .out_screen_y (out_screen_y),
    .out_screen_z (out_screen_z),
    .out_screen_w (out_screen_w),
    .out_w_zero   (out_w_zero),
    .out_last_out (out_last_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // exact row sum m0*x + m1*y + m2*z + (t << 16), q32.32
  function automatic logic signed [67:0] row_sum(input logic [REG_W-1:0] ra,
                                                 input logic [REG_W-1:0] rb,
                                                 input vertex_t v);
    logic signed [67:0] acc;
    acc = 68'(signed'(ra[31:0])) * 68'(v.px);
    acc += 68'(signed'(ra[63:32])) * 68'(v.py);
    acc += 68'(signed'(rb[31:0])) * 68'(v.pz);
    acc += 68'(signed'(rb[63:32])) <<< 16;
    return acc;
  endfunction

  // trunc(16*c/w) with saturation to signed 32 bits
  function automatic logic [31:0] persp_div(input logic signed [67:0] c,
                                            input logic signed [67:0] w);
    logic [71:0] cm, wm, q, lim;
    logic        neg;
    cm  = c < 0 ? 72'(-c) : 72'(c);
    wm  = w < 0 ? 72'(-w) : 72'(w);
    neg = (c < 0) != (w < 0);
    q   = (cm << 4) / wm;
    lim = neg ? 72'h8000_0000 : 72'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? 32'(-q) : q[31:0];
  endfunction

  function automatic screen_vtx_t transform_vertex(input vertex_t v);
    screen_vtx_t        s;
    logic signed [67:0] sum [4];
    for (int i = 0; i < 4; i++) sum[i] = row_sum(matrix[2*i], matrix[2*i+1], v);
    if (v.has_color) begin
      s.r = 8'((16'(v.r) * 2) / 3);
      s.g = 8'((16'(v.g) * 2) / 3);
      s.b = 8'((16'(v.b) * 2) / 3);
      s.a = v.a[7:1];
    end else begin
      s.r = NO_COLOR;
      s.g = NO_COLOR;
      s.b = NO_COLOR;
      s.a = 7'd127;
    end
    s.w_zero = (sum[3] == 0);
    if (s.w_zero) begin
      s.sx = '0; s.sy = '0; s.sz = '0; s.sw = '0;
    end else begin
      s.sx = persp_div(sum[0], sum[3]);
      s.sy = persp_div(sum[1], sum[3]);
      s.sz = persp_div(sum[2], sum[3]);
      s.sw = persp_div(sum[3], sum[3]);
    end
    s.last = v.last;
    return s;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h (cycle %0d)", field, got, want, cycle_cnt);
    mismatches++;
  endtask

  // result side: check each accepted request, then pick the next stall
  always @(posedge clk) begin
    screen_vtx_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_vtx.size() == 0) begin
          report_mismatch("unexpected result", '0, '0);
        end else begin
          want = pending_vtx.pop_front();
          if (out_red_out !== want.r)
            report_mismatch("red", 32'(out_red_out), 32'(want.r));
          if (out_green_out !== want.g)
            report_mismatch("green", 32'(out_green_out), 32'(want.g));
          if (out_blue_out !== want.b)
            report_mismatch("blue", 32'(out_blue_out), 32'(want.b));
          if (out_alpha_out !== want.a)
            report_mismatch("alpha", 32'(out_alpha_out), 32'(want.a));
          if (out_screen_x  !== want.sx)     report_mismatch("screen_x", out_screen_x, want.sx);
          if (out_screen_y  !== want.sy)     report_mismatch("screen_y", out_screen_y, want.sy);
          if (out_screen_z  !== want.sz)     report_mismatch("screen_z", out_screen_z, want.sz);
          if (out_screen_w  !== want.sw)     report_mismatch("screen_w", out_screen_w, want.sw);
          if (out_w_zero !== want.w_zero)
            report_mismatch("w_zero", 32'(out_w_zero), 32'(want.w_zero));
          if (out_last_out !== want.last)
            report_mismatch("last", 32'(out_last_out), 32'(want.last));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[vertex_transform_project_top] ERROR");
      $finish;
    end
  end

  // one vertex request, with an optional idle gap ahead of it
  task automatic send_vertex(input vertex_t v, input bit typed, input screen_vtx_t res);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pos_x     <= v.px;
    in_pos_y     <= v.py;
    in_pos_z     <= v.pz;
    in_has_color <= v.has_color;
    in_red_in    <= v.r;
    in_green_in  <= v.g;
    in_blue_in   <= v.b;
    in_alpha_in  <= v.a;
    in_last_in   <= v.last;
    do @(posedge clk); while (in_stall);
    // the matrix is stable during a phase, so predict at accept
    pending_vtx.push_back(typed ? res : transform_vertex(v));
  endtask

  // wait until every result is back and the pipe has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_vtx.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_REGS) matrix[idx[CFG_SEL_W-1:0]] = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coef(input int flavor);
    logic [31:0] c;
    case (flavor)
      COEF_SMALL: begin
        c = $urandom_range(32'h0004_0000);
        if ($urandom_range(1)) c = -c;
      end
      COEF_FULL: begin
        c = $urandom;
      end
      default: begin
        case ($urandom_range(4))
          0: c = 32'h7fff_ffff;
          1: c = 32'h8000_0000;
          2: c = 32'h0000_0000;
          3: c = 32'hffff_ffff;
          default: c = 32'h0001_0000;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [31:0] pick_pos();
    logic [31:0] p;
    case ($urandom_range(9))
      0, 1: p = $urandom;
      2: p = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: p = 32'h0;
      default: begin
        p = $urandom_range(32'h0010_0000);
        if ($urandom_range(1)) p = -p;
      end
    endcase
    return p;
  endfunction

  function automatic vertex_t pick_vertex();
    vertex_t v;
    v.px        = pick_pos();
    v.py        = pick_pos();
    v.pz        = pick_pos();
    v.has_color = 1'($urandom_range(1));
    v.r         = 8'($urandom_range(255));
    v.g         = 8'($urandom_range(255));
    v.b         = 8'($urandom_range(255));
    v.a         = 8'($urandom_range(255));
    v.last      = ($urandom_range(7) == 0);
    return v;
  endfunction

  function automatic vertex_t mk_vtx(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z, input logic hc,
                                     input logic [7:0] c, input logic [7:0] a,
                                     input logic lst);
    vertex_t v;
    v = '{px: x, py: y, pz: z, has_color: hc, r: c, g: c, b: c, a: a, last: lst};
    return v;
  endfunction

  function automatic screen_vtx_t mk_res(input logic [7:0] c, input logic [6:0] a,
                                         input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z, input logic [31:0] w,
                                         input logic wz, input logic lst);
    screen_vtx_t s;
    s = '{r: c, g: c, b: c, a: a, sx: x, sy: y, sz: z, sw: w, w_zero: wz, last: lst};
    return s;
  endfunction

  function automatic row_t mk_row(input bit wr, input logic [CFG_IDX_W-1:0] idx,
                                  input logic [REG_W-1:0] val, input vertex_t v,
                                  input bit typed, input screen_vtx_t res);
    row_t r;
    r.wr_cfg = wr;
    r.idx    = idx;
    r.val    = val;
    r.v      = v;
    r.typed  = typed;
    r.res    = res;
    return r;
  endfunction

  task automatic load_vectors();
    screen_vtx_t none;
    none = '0;
    // identity matrix out of reset
    vec_rows.push_back(mk_row(0, REG_X_A, '0, mk_vtx(0, 0, 0, 0, 8'h00, 8'h00, 0), 1,
                              mk_res(8'd127, 7'd127, 0, 0, 0, SCREEN_ONE, 0, 0)));
    vec_rows.push_back(mk_row(0, REG_X_A, '0,
                              mk_vtx(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 1,
                                     8'hff, 8'hff, 1), 1,
                              mk_res(8'd170, 7'd127, 16, 32, -48, SCREEN_ONE, 0, 1)));
    vec_rows.push_back(mk_row(0, REG_X_A, '0,
                              mk_vtx(32'h7fff_ffff, 32'h8000_0000, 0, 1, 8'h00, 8'h00, 0), 1,
                              mk_res(8'd0, 7'd0, 524287, -524288, 0, SCREEN_ONE, 0, 0)));
    // colour bytes ignored without has_color
    vec_rows.push_back(mk_row(0, REG_X_A, '0,
                              mk_vtx(32'h0000_8000, 0, 32'h0000_0001, 0, 8'hff, 8'hff, 1), 1,
                              mk_res(8'd127, 7'd127, 8, 0, 0, SCREEN_ONE, 0, 1)));
    vec_rows.push_back(mk_row(0, REG_X_A, '0,
                              mk_vtx(32'hffff_8001, 32'h0000_0fff, 32'h1234_5678, 1,
                                     8'h01, 8'h03, 0), 0, none));
    vec_rows.push_back(mk_row(0, REG_X_A, '0,
                              mk_vtx(32'h5555_aaaa, 32'haaaa_5555, 32'h0, 1,
                                     8'h80, 8'h7f, 1), 0, none));
    // tiny w so the quotients saturate both ways
    vec_rows.push_back(mk_row(1, REG_W_B, 64'h0000_0001_0000_0000,
                              mk_vtx(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 1,
                                     8'h02, 8'h01, 0), 1,
                              mk_res(8'd1, 7'd0, POS_LIMIT, NEG_LIMIT, 16, SCREEN_ONE, 0, 0)));
    vec_rows.push_back(mk_row(0, REG_X_A, '0,
                              mk_vtx(32'h0000_0123, 32'hffff_fedc, 32'h8000_0000, 0,
                                     8'h00, 8'h00, 1), 0, none));
    // w row all zero: flagged, coordinates cleared, colour kept
    vec_rows.push_back(mk_row(1, REG_W_B, 64'h0,
                              mk_vtx(32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 1,
                                     8'hff, 8'hfe, 1), 1,
                              mk_res(8'd170, 7'd127, 0, 0, 0, 0, 1, 1)));
    vec_rows.push_back(mk_row(0, REG_X_A, '0,
                              mk_vtx(32'hffff_ffff, 32'h0, 32'h0000_0001, 0,
                                     8'h00, 8'h00, 0), 0, none));
    // translation only, negative w
    vec_rows.push_back(mk_row(1, REG_W_B, 64'hfffe_0000_0000_0000,
                              mk_vtx(32'h0003_0000, 32'hfff0_0000, 32'h0000_4000, 1,
                                     8'hab, 8'hcd, 0), 0, none));
    vec_rows.push_back(mk_row(1, REG_X_B, 64'h7fff_ffff_8000_0000,
                              mk_vtx(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1,
                                     8'h55, 8'haa, 1), 0, none));
  endtask

  initial begin
    row_t    rw;
    vertex_t v;
    int      flavor;

    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_pos_x     = '0;
    in_pos_y     = '0;
    in_pos_z     = '0;
    in_has_color = 1'b0;
    in_red_in    = '0;
    in_green_in  = '0;
    in_blue_in   = '0;
    in_alpha_in  = '0;
    in_last_in   = 1'b0;
    out_stall    = 1'b0;
    mismatches   = 0;
    cycle_cnt    = 0;
    gap_pct      = 0;
    stall_pct    = 0;
    for (int i = 0; i < NUM_REGS; i++) matrix[i] = CFG_RESET[i];

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed vectors, back to back
    load_vectors();
    foreach (vec_rows[i]) begin
      rw = vec_rows[i];
      if (rw.wr_cfg) begin
        drain();
        write_reg(rw.idx, rw.val);
      end
      send_vertex(rw.v, rw.typed, rw.res);
    end

    // random phases, each with a fresh matrix and an idling mix picked by phase
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 79; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 79; end
        default: begin gap_pct = 36; stall_pct = 36; end
      endcase
      flavor = (ph == 2) ? COEF_FULL : (ph == 3) ? COEF_EXTREME : COEF_SMALL;
      for (int i = 0; i < NUM_REGS; i++)
        write_reg(CFG_IDX_W'(i), {pick_coef(flavor), pick_coef(flavor)});
      // a diagonal-heavy w keeps most quotients inside range
      if (ph == 1 || ph == 4)
        write_reg(REG_W_B, {32'h0001_0000 + pick_coef(COEF_SMALL), pick_coef(COEF_SMALL)});
      write_reg(REG_UNUSED, {$urandom, $urandom});
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        v = pick_vertex();
        send_vertex(v, 0, '0);
        // quiet stretches inside the idle phases too
        if (n == PHASE_ITEMS / 2 && ph > 0) begin
          gap_pct = 0;
          stall_pct = 0;
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("[vertex_transform_project_top] OK");
    end else begin
      $display("[vertex_transform_project_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/vtp_pkg.sv
rtl/core/vtp_front.sv
rtl/core/vtp_queue.sv
rtl/core/vtp_back.sv
rtl/core/vertex_transform_project_top.sv
sim/tb.sv
